// File: hw/rtl/bole_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bole_pkg
// Shared sizes, request kinds, status codes and the storage command bundle
// for the bounded ordered list engine.
// ----------------------------------------------------------------------------
package bole_pkg;

   localparam int CAPACITY = 16;
   localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int DATA_W   = 32;

   typedef enum logic [3:0] {
      KIND_CLEAR     = 4'd0,
      KIND_INS_HEAD  = 4'd1,
      KIND_INS_TAIL  = 4'd2,
      KIND_DEL_HEAD  = 4'd3,
      KIND_READ_HEAD = 4'd4,
      KIND_SEARCH    = 4'd5,
      KIND_DEL_FIRST = 4'd6,
      KIND_DEL_ALL   = 4'd7,
      KIND_DUMP      = 4'd8
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   typedef struct packed {
      logic              wr_en;
      logic [IDX_W-1:0]  wr_addr;
      logic [DATA_W-1:0] wr_data;
      logic [IDX_W-1:0]  rd_addr;
   } store_cmd_type;

endpackage

// File: hw/rtl/bole_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bole_store
// Element storage: one write port and one read port with registered data.
// ----------------------------------------------------------------------------
module bole_store
   import bole_pkg::*;
(
   input  logic              clock,
   input  store_cmd_type     cmd,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [CAPACITY];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[cmd.wr_addr] <= cmd.wr_data;
      end
      rd_data_ff <= mem[cmd.rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/bounded_ordered_list_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_ordered_list_engine
// Ordered list of signed 32-bit values held compactly in a small memory and
// walked one entry at a time by a sequencer sharing a single compare unit.
// ----------------------------------------------------------------------------
//  channel | direction | ports                                 | handshake
//  req     | in        | req_kind, req_value                   | req_valid / req_ready
//  rsp     | out       | rsp_status, rsp_found, rsp_element,   | rsp_valid / rsp_ready
//          |           | rsp_position, rsp_count, rsp_last     |
//
//  Clear, full insert, empty-list cases and unused kinds answer from idle; tail insert
//  writes, then answers; read head reads, then answers; head insert moves each entry up
//  one place, last first, then writes the head. Search and deletes walk entries (memory
//  read, then compare and write back); dump answers per element. A held response stalls.
//  Reset clears the state and the count only; the store needs no clearing pass.
//  One transaction in flight: req_ready is low until its last response is taken.
// ----------------------------------------------------------------------------
module bounded_ordered_list_engine
   import bole_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [3:0]         req_kind,
   input  logic signed [31:0] req_value,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [1:0]         rsp_status,
   output logic               rsp_found,
   output logic signed [31:0] rsp_element,
   output logic [4:0]         rsp_position,
   output logic [4:0]         rsp_count,
   output logic               rsp_last
);

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_READ = 5'b00010,
      ST_EVAL = 5'b00100,
      ST_PUT  = 5'b01000,
      ST_RESP = 5'b10000
   } state_type;

   state_type         state_ff, state_in;
   logic [3:0]        kind_ff, kind_in;
   logic [DATA_W-1:0] value_ff, value_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [CNT_W-1:0]  wr_ff, wr_in;
   logic              hit_ff, hit_in;

   logic [1:0]        rsp_status_ff;
   logic              rsp_found_ff;
   logic [DATA_W-1:0] rsp_element_ff;
   logic [4:0]        rsp_position_ff;
   logic [4:0]        rsp_count_ff;
   logic              rsp_last_ff;

   logic              load;
   status_type        ld_status;
   logic              ld_found;
   logic [DATA_W-1:0] ld_element;
   logic [CNT_W-1:0]  ld_pos;
   logic              ld_last;
   logic [CNT_W+4:0]  cnt_pad;
   logic [CNT_W+4:0]  pos_pad;

   store_cmd_type     cmd;
   logic [DATA_W-1:0] rd_data;
   logic              eq;
   logic              skip;
   logic              last_i;
   logic [CNT_W-1:0]  idx_plus1;
   logic [CNT_W-1:0]  wr_next;

   bole_store u_store (
      .clock   (clock),
      .cmd     (cmd),
      .rd_data (rd_data)
   );

   assign idx_plus1 = CNT_W'(idx_ff) + CNT_W'(1);
   assign last_i    = (idx_plus1 == count_ff);
   assign eq        = (rd_data == value_ff);
   assign skip      = ((kind_ff == KIND_DEL_HEAD) && (idx_ff == '0)) ||
                      ((kind_ff == KIND_DEL_FIRST) && !hit_ff && eq) ||
                      ((kind_ff == KIND_DEL_ALL) && eq);
   assign wr_next   = skip ? wr_ff : wr_ff + CNT_W'(1);

   always_comb begin
      state_in    = state_ff;
      kind_in     = kind_ff;
      value_in    = value_ff;
      count_in    = count_ff;
      idx_in      = idx_ff;
      wr_in       = wr_ff;
      hit_in      = hit_ff;
      load        = 1'b0;
      ld_status   = STATUS_OK;
      ld_found    = 1'b0;
      ld_element  = '0;
      ld_pos      = '0;
      ld_last     = 1'b1;
      cmd.wr_en   = 1'b0;
      cmd.wr_addr = wr_ff[IDX_W-1:0];
      cmd.wr_data = value_ff;
      cmd.rd_addr = idx_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               kind_in  = req_kind;
               value_in = req_value;
               idx_in   = '0;
               wr_in    = '0;
               hit_in   = 1'b0;
               case (req_kind)
                  KIND_CLEAR: begin
                     count_in = '0;
                     load     = 1'b1;
                     state_in = ST_RESP;
                  end
                  KIND_INS_HEAD, KIND_INS_TAIL: begin
                     if (count_ff == CNT_W'(CAPACITY)) begin
                        ld_status = STATUS_FULL;
                        load      = 1'b1;
                        state_in  = ST_RESP;
                     end else if (req_kind == KIND_INS_TAIL) begin
                        wr_in    = count_ff;
                        state_in = ST_PUT;
                     end else if (count_ff == '0) begin
                        state_in = ST_PUT;
                     end else begin
                        idx_in   = IDX_W'(count_ff - CNT_W'(1));
                        state_in = ST_READ;
                     end
                  end
                  KIND_DEL_HEAD, KIND_READ_HEAD, KIND_SEARCH, KIND_DEL_FIRST,
                  KIND_DEL_ALL, KIND_DUMP: begin
                     if (count_ff == '0) begin
                        ld_status = STATUS_EMPTY;
                        load      = 1'b1;
                        state_in  = ST_RESP;
                     end else begin
                        state_in = ST_READ;
                     end
                  end
                  default: begin
                     load     = 1'b1;
                     state_in = ST_RESP;
                  end
               endcase
            end
         end
         ST_READ: begin
            state_in = ST_EVAL;
         end
         ST_EVAL: begin
            case (kind_ff)
               KIND_INS_HEAD: begin
                  cmd.wr_en   = 1'b1;
                  cmd.wr_addr = idx_ff + IDX_W'(1);
                  cmd.wr_data = rd_data;
                  if (idx_ff == '0) begin
                     wr_in    = '0;
                     state_in = ST_PUT;
                  end else begin
                     idx_in   = idx_ff - IDX_W'(1);
                     state_in = ST_READ;
                  end
               end
               KIND_READ_HEAD: begin
                  ld_element = rd_data;
                  load       = 1'b1;
                  state_in   = ST_RESP;
               end
               KIND_SEARCH: begin
                  if (eq) begin
                     ld_found = 1'b1;
                     ld_pos   = idx_plus1;
                     load     = 1'b1;
                     state_in = ST_RESP;
                  end else if (last_i) begin
                     load     = 1'b1;
                     state_in = ST_RESP;
                  end else begin
                     idx_in   = idx_ff + IDX_W'(1);
                     state_in = ST_READ;
                  end
               end
               KIND_DEL_HEAD, KIND_DEL_FIRST, KIND_DEL_ALL: begin
                  cmd.wr_en   = !skip;
                  cmd.wr_data = rd_data;
                  wr_in       = wr_next;
                  hit_in      = hit_ff || skip;
                  if (last_i) begin
                     count_in = wr_next;
                     ld_found = (hit_ff || skip) && (kind_ff != KIND_DEL_HEAD);
                     load     = 1'b1;
                     state_in = ST_RESP;
                  end else begin
                     idx_in   = idx_ff + IDX_W'(1);
                     state_in = ST_READ;
                  end
               end
               KIND_DUMP: begin
                  ld_element = rd_data;
                  ld_pos     = idx_plus1;
                  ld_last    = last_i;
                  load       = 1'b1;
                  state_in   = ST_RESP;
               end
               default: begin
                  load     = 1'b1;
                  state_in = ST_RESP;
               end
            endcase
         end
         ST_PUT: begin
            cmd.wr_en = 1'b1;
            count_in  = count_ff + CNT_W'(1);
            load      = 1'b1;
            state_in  = ST_RESP;
         end
         ST_RESP: begin
            if (rsp_ready) begin
               if ((kind_ff == KIND_DUMP) && !rsp_last_ff) begin
                  idx_in   = idx_ff + IDX_W'(1);
                  state_in = ST_READ;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign cnt_pad = {5'b0, count_in};
   assign pos_pad = {5'b0, ld_pos};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff  <= kind_in;
      value_ff <= value_in;
      idx_ff   <= idx_in;
      wr_ff    <= wr_in;
      hit_ff   <= hit_in;
      if (load) begin
         rsp_status_ff   <= ld_status;
         rsp_found_ff    <= ld_found;
         rsp_element_ff  <= ld_element;
         rsp_position_ff <= pos_pad[4:0];
         rsp_count_ff    <= cnt_pad[4:0];
         rsp_last_ff     <= ld_last;
      end
   end

   assign req_ready    = (state_ff == ST_IDLE);
   assign rsp_valid    = (state_ff == ST_RESP);
   assign rsp_status   = rsp_status_ff;
   assign rsp_found    = rsp_found_ff;
   assign rsp_element  = rsp_element_ff;
   assign rsp_position = rsp_position_ff;
   assign rsp_count    = rsp_count_ff;
   assign rsp_last     = rsp_last_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("element count above capacity");

   a_one_side: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("request accepted while a response is pending");

   a_compact_behind: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EVAL && (kind_ff == KIND_DEL_HEAD || kind_ff == KIND_DEL_FIRST ||
       kind_ff == KIND_DEL_ALL)) |-> (wr_ff <= CNT_W'(idx_ff)))
      else $error("compaction write index ahead of read index");

   a_last_frees: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && rsp_last) |=> req_ready)
      else $error("engine not ready after final response");

   a_clear_count: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_kind == KIND_CLEAR) |=> (rsp_valid && rsp_count == 5'd0))
      else $error("clear did not report an empty list");

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the bounded ordered list engine. An initial block
// queues a short directed sequence and then segments of random requests with
// varying insert/delete mix. A clocked driver presents them with random
// gaps, updates an in-bench list predictor on every accepted transaction and
// queues the expected responses; a clocked monitor stalls rsp_ready at random
// and checks each response field by field against the oldest expectation.
// ----------------------------------------------------------------------------
module testbench
   import bole_pkg::*;
();

   localparam int          QUIET_TAIL = 40;
   localparam int          STALL_MAX  = 4000;
   localparam int          SEG_LEN    = 30;
   localparam int          SEG_COUNT  = 8;
   localparam logic [3:0]  KIND_SPARE = 4'd9;
   localparam logic [3:0]  KIND_LAST  = 4'd15;

   typedef struct packed {
      status_type  status;
      logic        found;
      logic [31:0] element;
      logic [4:0]  position;
      logic [4:0]  count;
      logic        last;
   } rsp_fields_type;

   typedef struct {
      logic [3:0]  kind;
      logic [31:0] value;
      bit          drain;
      bit          calm;
   } req_item_type;

   logic               clock;
   logic               reset     = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [3:0]         req_kind  = '0;
   logic signed [31:0] req_value = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [1:0]         rsp_status;
   logic               rsp_found;
   logic signed [31:0] rsp_element;
   logic [4:0]         rsp_position;
   logic [4:0]         rsp_count;
   logic               rsp_last;

   req_item_type   item_queue[$];
   rsp_fields_type rsp_expected[$];
   logic [31:0]    list_mem[CAPACITY];
   int             list_len;
   logic [31:0]    value_pool[4];
   bit             seg_calm;

   int n_errors;
   int n_sent;
   int n_results;
   int n_full;
   int n_empty;
   int idle_left;
   int stall_left;
   int quiet_cycles;

   bounded_ordered_list_engine u_top (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_kind     (req_kind),
      .req_value    (req_value),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_status   (rsp_status),
      .rsp_found    (rsp_found),
      .rsp_element  (rsp_element),
      .rsp_position (rsp_position),
      .rsp_count    (rsp_count),
      .rsp_last     (rsp_last)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // list predictor: applies one request, queues the responses it produces
   function automatic void list_apply(logic [3:0] kind, logic [31:0] value);
      rsp_fields_type r;
      int             kept;
      r      = '0;
      r.last = 1'b1;
      case (kind)
         KIND_CLEAR: list_len = 0;
         KIND_INS_HEAD, KIND_INS_TAIL: begin
            if (list_len >= CAPACITY) begin
               r.status = STATUS_FULL;
            end else begin
               if (kind == KIND_INS_HEAD) begin
                  for (int i = list_len; i > 0; i--) list_mem[i] = list_mem[i-1];
                  list_mem[0] = value;
               end else begin
                  list_mem[list_len] = value;
               end
               list_len++;
            end
         end
         KIND_DEL_HEAD, KIND_READ_HEAD, KIND_SEARCH,
         KIND_DEL_FIRST, KIND_DEL_ALL, KIND_DUMP: begin
            if (list_len == 0) begin
               r.status = STATUS_EMPTY;
            end else begin
               case (kind)
                  KIND_DEL_HEAD: begin
                     for (int i = 0; i + 1 < list_len; i++) list_mem[i] = list_mem[i+1];
                     list_len--;
                  end
                  KIND_READ_HEAD: r.element = list_mem[0];
                  KIND_SEARCH: begin
                     for (int i = 0; i < list_len; i++) begin
                        if (!r.found && list_mem[i] == value) begin
                           r.found    = 1'b1;
                           r.position = 5'(i + 1);
                        end
                     end
                  end
                  KIND_DEL_FIRST: begin
                     kept = 0;
                     for (int i = 0; i < list_len; i++) begin
                        if (!r.found && list_mem[i] == value) begin
                           r.found = 1'b1;
                        end else begin
                           list_mem[kept] = list_mem[i];
                           kept++;
                        end
                     end
                     list_len = kept;
                  end
                  KIND_DEL_ALL: begin
                     kept = 0;
                     for (int i = 0; i < list_len; i++) begin
                        if (list_mem[i] == value) begin
                           r.found = 1'b1;
                        end else begin
                           list_mem[kept] = list_mem[i];
                           kept++;
                        end
                     end
                     list_len = kept;
                  end
                  default: begin
                     r.count = 5'(list_len);
                     for (int i = 0; i < list_len; i++) begin
                        r.element  = list_mem[i];
                        r.position = 5'(i + 1);
                        r.last     = (i + 1 == list_len);
                        rsp_expected.push_back(r);
                     end
                     return;
                  end
               endcase
            end
         end
         default: ;
      endcase
      r.count = 5'(list_len);
      rsp_expected.push_back(r);
   endfunction

   function automatic bit idling_allowed();
      return item_queue.size() > QUIET_TAIL && !item_queue[0].calm;
   endfunction

   function automatic void add_item(logic [3:0] kind, logic [31:0] value);
      req_item_type it;
      it.kind  = kind;
      it.value = value;
      it.drain = 1'b0;
      it.calm  = seg_calm;
      item_queue.push_back(it);
   endfunction

   function automatic logic [31:0] pick_value();
      case ($urandom_range(0, 9))
         0:       return 32'h8000_0000;
         1:       return 32'h7fff_ffff;
         2:       return 32'hffff_ffff;
         3:       return 32'h0000_0000;
         4, 5:    return $urandom;
         default: return value_pool[$urandom_range(0, 3)];
      endcase
   endfunction

   function automatic logic [3:0] pick_kind(int ins_pct);
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 3)
         return 4'($urandom_range(int'(KIND_DUMP) + 1, int'(KIND_LAST)));
      if (roll < 3 + ins_pct)
         return $urandom_range(0, 1) ? KIND_INS_HEAD : KIND_INS_TAIL;
      roll = $urandom_range(0, 20);
      if (roll == 0)
         return KIND_CLEAR;
      return 4'(int'(KIND_DEL_HEAD) + roll % 6);
   endfunction

   task automatic check_field(string name, logic [31:0] exp, logic [31:0] act);
      if (exp !== act) begin
         n_errors++;
         $display("%0t: rsp_%s mismatch, expected %h actual %h", $time, name, exp, act);
      end
   endtask

   // driver
   always @(posedge clock) begin
      req_item_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
         req_kind  <= '0;
         req_value <= '0;
         idle_left = 0;
      end else begin
         if (req_valid && req_ready) begin
            list_apply(req_kind, req_value);
            n_sent++;
         end
         if (!req_valid || req_ready) begin
            if (idle_left != 0) begin
               idle_left--;
               req_valid <= 1'b0;
            end else if (item_queue.size() == 0 ||
                         (item_queue[0].drain && rsp_expected.size() != 0)) begin
               req_valid <= 1'b0;
            end else if (idling_allowed() && $urandom_range(0, 7) == 0) begin
               idle_left = $urandom_range(0, 12);
               req_valid <= 1'b0;
            end else begin
               nxt = item_queue.pop_front();
               req_valid <= 1'b1;
               req_kind  <= nxt.kind;
               req_value <= nxt.value;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      rsp_fields_type exp;
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            n_results++;
            if (rsp_status == STATUS_FULL) n_full++;
            if (rsp_status == STATUS_EMPTY) n_empty++;
            if (rsp_expected.size() == 0) begin
               n_errors++;
               $display("%0t: unexpected response, status %0d element %h count %0d",
                        $time, rsp_status, rsp_element, rsp_count);
            end else begin
               exp = rsp_expected.pop_front();
               check_field("status", 32'(exp.status), 32'(rsp_status));
               check_field("found", 32'(exp.found), 32'(rsp_found));
               check_field("element", exp.element, rsp_element);
               check_field("position", 32'(exp.position), 32'(rsp_position));
               check_field("count", 32'(exp.count), 32'(rsp_count));
               check_field("last", 32'(exp.last), 32'(rsp_last));
            end
         end
         if (stall_left != 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else if (idling_allowed() && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 12);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= STALL_MAX) begin
            $display("%0t: no transaction for %0d cycles", $time, quiet_cycles);
            $display("[bounded_ordered_list_engine] ERROR");
            $finish;
         end
      end
   end

   initial begin
      int ins_pct[5] = '{70, 25, 50, 85, 15};
      foreach (value_pool[i]) value_pool[i] = $urandom;
      seg_calm = 1'b0;

      // empty-list cases
      add_item(KIND_DUMP,       32'h0);
      add_item(KIND_READ_HEAD,  32'h0);
      add_item(KIND_DEL_HEAD,   32'h0);
      add_item(KIND_SEARCH,     32'h7fff_ffff);
      add_item(KIND_DEL_FIRST,  32'h8000_0000);
      add_item(KIND_DEL_ALL,    32'hffff_ffff);
      add_item(KIND_SPARE,      32'h5555_aaaa);
      // build, inspect, delete
      add_item(KIND_INS_HEAD,   32'h7fff_ffff);
      add_item(KIND_INS_TAIL,   32'h8000_0000);
      add_item(KIND_INS_HEAD,   32'hffff_ffff);
      add_item(KIND_INS_TAIL,   32'h0000_0000);
      add_item(KIND_INS_TAIL,   32'h8000_0000);
      add_item(KIND_READ_HEAD,  32'h0);
      add_item(KIND_SEARCH,     32'h8000_0000);
      add_item(KIND_SEARCH,     32'h1234_5678);
      add_item(KIND_DUMP,       32'h0);
      add_item(KIND_DEL_FIRST,  32'h8000_0000);
      add_item(KIND_DEL_ALL,    32'h1234_5678);
      add_item(KIND_DEL_ALL,    32'h8000_0000);
      add_item(KIND_DEL_HEAD,   32'h0);
      add_item(KIND_DUMP,       32'h0);
      add_item(KIND_LAST,       32'haaaa_5555);
      add_item(KIND_CLEAR,      32'h0);
      add_item(KIND_DUMP,       32'h0);

      // fill past capacity so full drops and 16-entry dumps occur early
      for (int i = 0; i < 18; i++)
         add_item($urandom_range(0, 1) ? KIND_INS_HEAD : KIND_INS_TAIL, pick_value());
      add_item(KIND_DUMP, 32'h0);

      for (int s = 0; s < SEG_COUNT; s++) begin
         seg_calm = (s % 4 == 3);
         for (int i = 0; i < SEG_LEN; i++) begin
            add_item(pick_kind(ins_pct[s % 5]), pick_value());
            if (i == 0 && (s == 2 || s == 5)) item_queue[$].drain = 1'b1;
         end
      end

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      while (item_queue.size() != 0 || req_valid) @(posedge clock);
      while (rsp_expected.size() != 0) @(posedge clock);
      repeat (64) @(posedge clock);

      $display("covered %0d requests and %0d responses over empty, partial and full lists,",
               n_sent, n_results);
      $display("including %0d inserts dropped when full and %0d empty-list responses",
               n_full, n_empty);
      if (n_errors == 0) begin
         $display("[bounded_ordered_list_engine] OK");
      end else begin
         $display("[bounded_ordered_list_engine] ERROR");
      end
      $finish;
   end

endmodule
